/* hw/rtl/multilevel_priority_fifo_scheduler_assert.svh */
// Assertion macros for the scheduler's checker file.
`ifndef MULTILEVEL_PRIORITY_FIFO_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_PRIORITY_FIFO_SCHEDULER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define MLPQ_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// Check a consequent in the cycle after its antecedent.
`define MLPQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

/* hw/rtl/mlpq_pkg.sv */
// Types, sizes and helpers shared by the multilevel queue scheduler.
`default_nettype none
package mlpq_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 16;
	localparam int LEVELS      = 4;
	localparam int LVL_W       = 2;
	localparam int ID_W        = 16;
	localparam int STATUS_W    = 3;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W      = LVL_W + PTR_W;

	typedef enum logic [1:0] {
		CMD_ADMIT  = 2'd0,
		CMD_FINISH = 2'd1,
		CMD_TIMEUP = 2'd2,
		CMD_START  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_HELD     = 3'd1,
		ST_BAD_PRIO = 3'd2,
		ST_FULL     = 3'd3,
		ST_NO_RUN   = 3'd4
	} status_t;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [ID_BITS-1:0] tid_t;

	// One result as handed from the sequencer to the output register
	typedef struct packed {
		status_t           status;
		logic              run_valid;
		logic [ID_W-1:0]   run_id;
		logic [LVL_W-1:0]  run_level;
		logic              ret_valid;
		logic [ID_W-1:0]   ret_id;
	} result_t;

	// Port requests towards the queue store
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		tid_t              wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// Advance a ring pointer with wrap at the queue depth
	function automatic ptr_t next_ptr(input ptr_t p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/multilevel_priority_fifo_scheduler.sv */
// Top level of the multilevel priority FIFO scheduler.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------------
//   in      | in_valid / in_ready | command, task_id, arrived, is_realtime,
//           |                     | task_priority
//   out     | out_valid/out_ready | status, running_valid, running_id,
//           |                     | running_level, retired_valid, retired_id
//
// An admit, a refused command or a start with the slot taken passes from EXEC
// to RESP; a finish, time-up or start that dispatches also passes through DISP,
// and through RDATA when a queue head is read from the store (registered RAM read).
// arst_n clears all pointers, counts and the running slot; the store needs no
// clearing. A waiting result sits in the output register while the next
// command is taken; the sequencer stalls only when that register is still full.
`default_nettype none
module multilevel_priority_fifo_scheduler import mlpq_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire logic [1:0]          command,
	input  wire logic [ID_W-1:0]     task_id,
	input  wire logic                arrived,
	input  wire logic                is_realtime,
	input  wire logic [LVL_W-1:0]    task_priority,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      logic [STATUS_W-1:0] status,
	output      logic                running_valid,
	output      logic [ID_W-1:0]     running_id,
	output      logic [LVL_W-1:0]    running_level,
	output      logic                retired_valid,
	output      logic [ID_W-1:0]     retired_id
);
	logic     res_valid;
	logic     res_ready;
	result_t  res;
	mem_req_t mem_req;
	tid_t     mem_rdata;
	logic     out_valid_q;
	result_t  out_q;

	mlpq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (in_valid),
		.cmd_ready     (in_ready),
		.command       (command),
		.task_id       (task_id),
		.arrived       (arrived),
		.is_realtime   (is_realtime),
		.task_priority (task_priority),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.mem_req       (mem_req),
		.mem_rdata     (mem_rdata)
	);

	mlpq_ram #(
		.DATA_W (ID_BITS),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	// Output register: refill when empty or when the held result transfers
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign running_valid = out_q.run_valid;
	assign running_id    = out_q.run_id;
	assign running_level = out_q.run_level;
	assign retired_valid = out_q.ret_valid;
	assign retired_id    = out_q.ret_id;
endmodule
`default_nettype wire

/* hw/rtl/mlpq_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module mlpq_ram #(
	parameter int DATA_W = 16,
	parameter int ADDR_W = 6
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output      logic [DATA_W-1:0] rdata
);
	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/mlpq_ctrl.sv */
// Command sequencer: queue pointers, running slot and store accesses.
`default_nettype none
module mlpq_ctrl import mlpq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output      logic              cmd_ready,
	input  wire logic [1:0]        command,
	input  wire logic [ID_W-1:0]   task_id,
	input  wire logic              arrived,
	input  wire logic              is_realtime,
	input  wire logic [LVL_W-1:0]  task_priority,
	output      logic              res_valid,
	input  wire logic              res_ready,
	output      result_t           res,
	output      mem_req_t          mem_req,
	input  wire tid_t              mem_rdata
);
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_DISP  = 5'b00100,
		S_RDATA = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	tid_t               id_q;
	logic               arrived_q;
	logic               rt_q;
	logic [LVL_W-1:0]   prio_q;
	ptr_t               head_q  [LEVELS];
	ptr_t               tail_q  [LEVELS];
	cnt_t               count_q [LEVELS];
	logic               run_valid_q;
	tid_t               run_task_q;
	logic [LVL_W-1:0]   run_level_q;
	status_t            status_q;
	logic               ret_valid_q;
	tid_t               ret_id_q;

	logic [LVL_W-1:0]   admit_lvl;
	logic [LVL_W-1:0]   push_lvl;
	tid_t               push_id;
	logic               push_full;
	logic [LVL_W-1:0]   sel_lvl;
	logic               sel_any;

	// Pick the push target for the command in hand
	assign admit_lvl = rt_q ? '0 : prio_q;
	assign push_lvl  = (cmd_q == CMD_ADMIT) ? admit_lvl : run_level_q;
	assign push_id   = (cmd_q == CMD_ADMIT) ? id_q : run_task_q;
	assign push_full = (count_q[push_lvl] == CNT_W'(QUEUE_DEPTH));

	// Find the highest-priority non-empty queue
	always_comb begin
		sel_lvl = '0;
		sel_any = 1'b0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			if (count_q[i] != '0) begin
				sel_lvl = LVL_W'(i);
				sel_any = 1'b1;
			end
		end
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP);

	// Form the result from the settled slot
	always_comb begin
		res.status    = status_q;
		res.run_valid = run_valid_q;
		res.run_id    = run_valid_q ? ID_W'(run_task_q) : '0;
		res.run_level = run_valid_q ? run_level_q : '0;
		res.ret_valid = ret_valid_q;
		res.ret_id    = ret_valid_q ? ID_W'(ret_id_q) : '0;
	end

	// Drive the store: writes only in EXEC, reads only in DISP, so a
	// pushed entry has landed before any read of it.
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = {push_lvl, tail_q[push_lvl]};
		mem_req.wdata = push_id;
		mem_req.re    = 1'b0;
		mem_req.raddr = {sel_lvl, head_q[sel_lvl]};
		if (state_q == S_EXEC) begin
			if (cmd_q == CMD_ADMIT) begin
				mem_req.we = arrived_q && (rt_q || (prio_q != '0)) && !push_full;
			end else if (cmd_q == CMD_TIMEUP) begin
				mem_req.we = run_valid_q && !push_full;
			end
		end
		if (state_q == S_DISP) begin
			mem_req.re = sel_any;
		end
	end

	// Sequence one command through the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			run_valid_q <= 1'b0;
			run_task_q  <= '0;
			run_level_q <= '0;
			ret_valid_q <= 1'b0;
			status_q    <= ST_OK;
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						status_q    <= ST_OK;
						ret_valid_q <= 1'b0;
						state_q     <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
					case (cmd_q)
						CMD_ADMIT: begin
							if (!arrived_q) begin
								status_q <= ST_HELD;
							end else if (!rt_q && prio_q == '0) begin
								status_q <= ST_BAD_PRIO;
							end else if (push_full) begin
								status_q <= ST_FULL;
							end else begin
								tail_q[push_lvl]  <= next_ptr(tail_q[push_lvl]);
								count_q[push_lvl] <= count_q[push_lvl] + CNT_W'(1);
							end
						end
						CMD_START: begin
							if (!run_valid_q) begin
								state_q <= S_DISP;
							end
						end
						CMD_FINISH: begin
							if (!run_valid_q) begin
								status_q <= ST_NO_RUN;
							end else begin
								ret_valid_q <= 1'b1;
								state_q     <= S_DISP;
							end
						end
						default: begin
							if (!run_valid_q) begin
								status_q <= ST_NO_RUN;
							end else begin
								if (push_full) begin
									status_q <= ST_FULL;
								end else begin
									tail_q[push_lvl]  <= next_ptr(tail_q[push_lvl]);
									count_q[push_lvl] <= count_q[push_lvl] + CNT_W'(1);
								end
								state_q <= S_DISP;
							end
						end
					endcase
				end
				S_DISP: begin
					if (sel_any) begin
						head_q[sel_lvl]  <= next_ptr(head_q[sel_lvl]);
						count_q[sel_lvl] <= count_q[sel_lvl] - CNT_W'(1);
						run_valid_q      <= 1'b1;
						run_level_q      <= sel_lvl;
						state_q          <= S_RDATA;
					end else begin
						run_valid_q <= 1'b0;
						run_task_q  <= '0;
						run_level_q <= '0;
						if (cmd_q == CMD_START) begin
							status_q <= ST_NO_RUN;
						end
						state_q <= S_RESP;
					end
				end
				S_RDATA: begin
					run_task_q <= mem_rdata;
					state_q    <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the command fields on transfer, and the retiring id on a finish
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q     <= cmd_t'(command);
			id_q      <= ID_BITS'(task_id);
			arrived_q <= arrived;
			rt_q      <= is_realtime;
			prio_q    <= task_priority;
		end
		if (state_q == S_EXEC && cmd_q == CMD_FINISH) begin
			ret_id_q <= run_task_q;
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/mlpq_checker.sv */
// Port-level checks for the multilevel priority FIFO scheduler.
`default_nettype none
`include "multilevel_priority_fifo_scheduler_assert.svh"
module mlpq_checker import mlpq_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [STATUS_W-1:0] status,
	input wire logic                running_valid,
	input wire logic [ID_W-1:0]     running_id,
	input wire logic [LVL_W-1:0]    running_level,
	input wire logic                retired_valid,
	input wire logic [ID_W-1:0]     retired_id
);
	// Hold a stalled result
	`MLPQ_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(running_id) && $stable(status))
	// An empty slot reads as zero
	`MLPQ_ASSERT_NOW(a_empty_slot, out_valid && !running_valid, running_id == '0 && running_level == '0)
	// No retirement means no retired id
	`MLPQ_ASSERT_NOW(a_no_retire, out_valid && !retired_valid, retired_id == '0)
	// A command answered with no-run leaves the slot empty
	`MLPQ_ASSERT_NOW(a_no_run, out_valid && status == ST_NO_RUN, !running_valid && !retired_valid)
	// A retirement always reports success
	`MLPQ_ASSERT_NOW(a_retire_ok, out_valid && retired_valid, status == ST_OK)
endmodule

bind multilevel_priority_fifo_scheduler mlpq_checker u_mlpq_checker (.*);
`default_nettype wire
